// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MSR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, sampled on clock, off during reset
`define MSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- sv/msr_pkg.sv -----
package msr_pkg;

   localparam int WIDTH    = 64;
   localparam int K_W      = $clog2(WIDTH);
   localparam int CNT_W    = K_W + 1;
   localparam int NR_LIMIT = 4096;
   localparam int Z_W      = $clog2(NR_LIMIT) + 1;

   typedef logic [WIDTH-1:0] word_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [Z_W-1:0]   zval_type;
   typedef logic [3:0]       sel_type;
   typedef logic [1:0]       pesel_type;
   typedef logic [1:0]       ressel_type;

   localparam sel_type SEL_ONE  = 4'd0;
   localparam sel_type SEL_RAWN = 4'd1;
   localparam sel_type SEL_NR   = 4'd2;
   localparam sel_type SEL_X    = 4'd3;
   localparam sel_type SEL_C    = 4'd4;
   localparam sel_type SEL_T    = 4'd5;
   localparam sel_type SEL_B    = 4'd6;
   localparam sel_type SEL_TT   = 4'd7;
   localparam sel_type SEL_PA   = 4'd8;
   localparam sel_type SEL_PR   = 4'd9;

   localparam logic PA_NR = 1'b0;
   localparam logic PA_Z  = 1'b1;

   localparam pesel_type PE_HALF_PM1 = 2'd0;
   localparam pesel_type PE_QTR_P1   = 2'd1;
   localparam pesel_type PE_Q        = 2'd2;
   localparam pesel_type PE_Q_HALF   = 2'd3;

   localparam ressel_type RES_ZERO = 2'd0;
   localparam ressel_type RES_NLSB = 2'd1;
   localparam ressel_type RES_PR   = 2'd2;
   localparam ressel_type RES_X    = 2'd3;

   typedef struct packed {
      logic       cap_n;
      logic       mul_start;
      sel_type    mul_a;
      sel_type    mul_b;
      sel_type    mul_dst;
      logic       pow_init;
      logic       pa_sel;
      pesel_type  pe_sel;
      logic       pe_shift;
      logic       q_init;
      logic       q_shift;
      logic       z_init;
      logic       z_inc;
      logic       m_from_s;
      logic       m_from_i;
      logic       i_init;
      logic       i_inc;
      logic       j_init;
      logic       j_inc;
      logic       b_from_c;
      logic       c_from_pr;
      logic       x_from_pr;
      logic       t_from_pr;
      logic       res_load;
      ressel_type res_sel;
      logic       res_found;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic p_two;
      logic p_small;
      logic p_3mod4;
      logic nr_zero;
      logic pr_one;
      logic pr_pm1;
      logic pe_zero;
      logic pe_lsb;
      logic q_lsb;
      logic z_lim;
      logic t_one;
      logic tt_one;
      logic i_lt_m;
      logic j_lt;
      logic mul_busy;
      logic mul_done;
   } sts_type;

endpackage

// ----- sv/msr_if.sv -----
interface msr_req_if import msr_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface msr_rsp_if import msr_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type root;
   logic     root_found;
   modport source (output valid, output root, output root_found, input ready);
   modport sink (input valid, input root, input root_found, output ready);
endinterface

// ----- sv/msr_mulmod.sv -----
module msr_mulmod import msr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type a,
   input  word_type b,
   input  word_type p,
   output logic     busy,
   output logic     done,
   output word_type r
);
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           phase_ff, phase_in;
   logic [K_W-1:0] k_ff, k_in;
   word_type       acc_ff, acc_in;
   word_type       a_ff, a_in;
   word_type       b_ff, b_in;
   word_type       addend;
   logic           use_add;
   logic [WIDTH:0] sum, diff;
   word_type       acc_step;

   always_comb begin
      addend   = phase_ff ? a_ff : acc_ff;
      use_add  = !phase_ff || b_ff[WIDTH-1];
      sum      = {1'b0, acc_ff} + {1'b0, addend};
      diff     = sum - {1'b0, p};
      acc_step = (sum >= {1'b0, p}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         k_in     = K_W'(WIDTH - 1);
         acc_in   = '0;
         a_in     = a;
         b_in     = b;
      end else if (busy_ff) begin
         if (use_add) begin
            acc_in = acc_step;
         end
         phase_in = !phase_ff;
         if (phase_ff) begin
            b_in = {b_ff[WIDTH-2:0], 1'b0};
            if (k_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign r    = acc_ff;
endmodule

// ----- sv/msr_datapath.sv -----
module msr_datapath import msr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_wr_en,
   input  word_type csr_wr_data,
   input  word_type req_value,
   input  cmd_type  cmd,
   output sts_type  sts,
   output word_type rsp_root,
   output logic     rsp_root_found
);
   word_type   modulus_ff;
   word_type   rawn_ff, nr_ff, x_ff, c_ff, t_ff, b_ff, tt_ff;
   word_type   pa_ff, pr_ff, pe_ff, q_ff;
   cnt_type    s_ff, m_ff, i_ff, j_ff;
   zval_type   z_ff;
   sel_type    dst_ff;
   word_type   res_root_ff, rsp_root_ff;
   logic       res_found_ff, rsp_found_ff;

   word_type   mul_a, mul_b, mul_r, pe_init, pa_init, res_val;
   logic       mul_busy, mul_done;
   logic [WIDTH:0]   q_inc;
   logic [CNT_W:0]   j_sum;

   function automatic word_type pick(input sel_type sel, input word_type one,
                                     input word_type rn, input word_type nr,
                                     input word_type x, input word_type c,
                                     input word_type t, input word_type b,
                                     input word_type tt, input word_type pa,
                                     input word_type pr);
      word_type v;
      case (sel)
         SEL_ONE:  v = one;
         SEL_RAWN: v = rn;
         SEL_NR:   v = nr;
         SEL_X:    v = x;
         SEL_C:    v = c;
         SEL_T:    v = t;
         SEL_B:    v = b;
         SEL_TT:   v = tt;
         SEL_PA:   v = pa;
         SEL_PR:   v = pr;
         default:  v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      mul_a = pick(cmd.mul_a, word_type'(1), rawn_ff, nr_ff, x_ff, c_ff, t_ff, b_ff,
                   tt_ff, pa_ff, pr_ff);
      mul_b = pick(cmd.mul_b, word_type'(1), rawn_ff, nr_ff, x_ff, c_ff, t_ff, b_ff,
                   tt_ff, pa_ff, pr_ff);
      q_inc = {1'b0, q_ff} + 1'b1;
      case (cmd.pe_sel)
         PE_HALF_PM1: pe_init = (modulus_ff - 1'b1) >> 1;
         PE_QTR_P1:   pe_init = (modulus_ff >> 2) + 1'b1;
         PE_Q:        pe_init = q_ff;
         PE_Q_HALF:   pe_init = q_inc[WIDTH:1];
         default:     pe_init = q_ff;
      endcase
      pa_init = (cmd.pa_sel == PA_Z) ? word_type'(z_ff) : nr_ff;
      case (cmd.res_sel)
         RES_ZERO: res_val = '0;
         RES_NLSB: res_val = word_type'(rawn_ff[0]);
         RES_PR:   res_val = pr_ff;
         RES_X:    res_val = x_ff;
         default:  res_val = '0;
      endcase
      j_sum = {1'b0, j_ff} + {1'b0, i_ff} + 1'b1;
   end

   msr_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .p     (modulus_ff),
      .busy  (mul_busy),
      .done  (mul_done),
      .r     (mul_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= word_type'(3);
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_n) rawn_ff <= req_value;
      if (cmd.mul_start) dst_ff <= cmd.mul_dst;
      if (mul_done && dst_ff == SEL_NR) nr_ff <= mul_r;
      if (mul_done && dst_ff == SEL_X) begin
         x_ff <= mul_r;
      end else if (cmd.x_from_pr) begin
         x_ff <= pr_ff;
      end
      if (mul_done && dst_ff == SEL_C) begin
         c_ff <= mul_r;
      end else if (cmd.c_from_pr) begin
         c_ff <= pr_ff;
      end
      if (mul_done && dst_ff == SEL_T) begin
         t_ff <= mul_r;
      end else if (cmd.t_from_pr) begin
         t_ff <= pr_ff;
      end
      if (mul_done && dst_ff == SEL_B) begin
         b_ff <= mul_r;
      end else if (cmd.b_from_c) begin
         b_ff <= c_ff;
      end
      if (mul_done && dst_ff == SEL_TT) tt_ff <= mul_r;
      if (mul_done && dst_ff == SEL_PA) begin
         pa_ff <= mul_r;
      end else if (cmd.pow_init) begin
         pa_ff <= pa_init;
      end
      if (mul_done && dst_ff == SEL_PR) begin
         pr_ff <= mul_r;
      end else if (cmd.pow_init) begin
         pr_ff <= word_type'(1);
      end
      if (cmd.pow_init) begin
         pe_ff <= pe_init;
      end else if (cmd.pe_shift) begin
         pe_ff <= pe_ff >> 1;
      end
      if (cmd.q_init) begin
         q_ff <= modulus_ff - 1'b1;
         s_ff <= '0;
      end else if (cmd.q_shift) begin
         q_ff <= q_ff >> 1;
         s_ff <= s_ff + 1'b1;
      end
      if (cmd.z_init) begin
         z_ff <= Z_W'(2);
      end else if (cmd.z_inc) begin
         z_ff <= z_ff + 1'b1;
      end
      if (cmd.m_from_s) begin
         m_ff <= s_ff;
      end else if (cmd.m_from_i) begin
         m_ff <= i_ff;
      end
      if (cmd.i_init) begin
         i_ff <= CNT_W'(1);
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.j_init) begin
         j_ff <= '0;
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.res_load) begin
         res_root_ff  <= res_val;
         res_found_ff <= cmd.res_found;
      end
      if (cmd.out_load) begin
         rsp_root_ff  <= res_root_ff;
         rsp_found_ff <= res_found_ff;
      end
   end

   always_comb begin
      sts.n_zero   = (rawn_ff == '0);
      sts.p_two    = (modulus_ff == word_type'(2));
      sts.p_small  = (modulus_ff < word_type'(2));
      sts.p_3mod4  = (modulus_ff[1:0] == 2'b11);
      sts.nr_zero  = (nr_ff == '0);
      sts.pr_one   = (pr_ff == word_type'(1));
      sts.pr_pm1   = (pr_ff == modulus_ff - 1'b1);
      sts.pe_zero  = (pe_ff == '0);
      sts.pe_lsb   = pe_ff[0];
      sts.q_lsb    = q_ff[0];
      sts.z_lim    = (z_ff >= Z_W'(NR_LIMIT)) ||
                     ({{WIDTH{1'b0}}, z_ff} >= {{Z_W{1'b0}}, modulus_ff});
      sts.t_one    = (t_ff == word_type'(1));
      sts.tt_one   = (tt_ff == word_type'(1));
      sts.i_lt_m   = (i_ff < m_ff);
      sts.j_lt     = (j_sum < {1'b0, m_ff});
      sts.mul_busy = mul_busy;
      sts.mul_done = mul_done;
   end

   assign rsp_root       = rsp_root_ff;
   assign rsp_root_found = rsp_found_ff;
endmodule

// ----- sv/msr_ctrl.sv -----
module msr_ctrl import msr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CLASS   = 5'd1;
   localparam logic [4:0] S_RED_W   = 5'd2;
   localparam logic [4:0] S_EUL_N   = 5'd3;
   localparam logic [4:0] S_POW     = 5'd4;
   localparam logic [4:0] S_POW_MW  = 5'd5;
   localparam logic [4:0] S_POW_SW  = 5'd6;
   localparam logic [4:0] S_POW_END = 5'd7;
   localparam logic [4:0] S_QDIV    = 5'd8;
   localparam logic [4:0] S_ZCHK    = 5'd9;
   localparam logic [4:0] S_TS      = 5'd10;
   localparam logic [4:0] S_SQ_W    = 5'd11;
   localparam logic [4:0] S_ORD     = 5'd12;
   localparam logic [4:0] S_BSQ     = 5'd13;
   localparam logic [4:0] S_BSQ_W   = 5'd14;
   localparam logic [4:0] S_XW      = 5'd15;
   localparam logic [4:0] S_CW      = 5'd16;
   localparam logic [4:0] S_TW      = 5'd17;
   localparam logic [4:0] S_FIN     = 5'd18;
   localparam logic [4:0] S_TM      = 5'd19;

   localparam logic [2:0] R_EUL_N  = 3'd0;
   localparam logic [2:0] R_ROOT34 = 3'd1;
   localparam logic [2:0] R_EUL_Z  = 3'd2;
   localparam logic [2:0] R_C      = 3'd3;
   localparam logic [2:0] R_X      = 3'd4;
   localparam logic [2:0] R_T      = 3'd5;

   logic [4:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap_n = 1'b1;
               state_in  = S_CLASS;
            end
         end
         S_CLASS: begin
            cmd.res_load = 1'b1;
            state_in     = S_FIN;
            if (sts.n_zero) begin
               cmd.res_sel   = RES_ZERO;
               cmd.res_found = 1'b1;
            end else if (sts.p_two) begin
               cmd.res_sel   = RES_NLSB;
               cmd.res_found = 1'b1;
            end else if (sts.p_small) begin
               cmd.res_sel = RES_ZERO;
            end else begin
               cmd.res_load  = 1'b0;
               cmd.mul_start = 1'b1;
               cmd.mul_a     = SEL_ONE;
               cmd.mul_b     = SEL_RAWN;
               cmd.mul_dst   = SEL_NR;
               state_in      = S_RED_W;
            end
         end
         S_RED_W: begin
            if (sts.mul_done) state_in = S_EUL_N;
         end
         S_EUL_N: begin
            if (sts.nr_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ZERO;
               state_in     = S_FIN;
            end else begin
               cmd.pow_init = 1'b1;
               cmd.pa_sel   = PA_NR;
               cmd.pe_sel   = PE_HALF_PM1;
               ret_in       = R_EUL_N;
               state_in     = S_POW;
            end
         end
         S_POW: begin
            if (sts.pe_zero) begin
               state_in = S_POW_END;
            end else if (sts.pe_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_a     = SEL_PR;
               cmd.mul_b     = SEL_PA;
               cmd.mul_dst   = SEL_PR;
               state_in      = S_POW_MW;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_a     = SEL_PA;
               cmd.mul_b     = SEL_PA;
               cmd.mul_dst   = SEL_PA;
               cmd.pe_shift  = 1'b1;
               state_in      = S_POW_SW;
            end
         end
         S_POW_MW: begin
            if (sts.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_a     = SEL_PA;
               cmd.mul_b     = SEL_PA;
               cmd.mul_dst   = SEL_PA;
               cmd.pe_shift  = 1'b1;
               state_in      = S_POW_SW;
            end
         end
         S_POW_SW: begin
            if (sts.mul_done) state_in = S_POW;
         end
         S_POW_END: begin
            case (ret_ff)
               R_EUL_N: begin
                  if (!sts.pr_one) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RES_ZERO;
                     state_in     = S_FIN;
                  end else if (sts.p_3mod4) begin
                     cmd.pow_init = 1'b1;
                     cmd.pa_sel   = PA_NR;
                     cmd.pe_sel   = PE_QTR_P1;
                     ret_in       = R_ROOT34;
                     state_in     = S_POW;
                  end else begin
                     cmd.q_init = 1'b1;
                     state_in   = S_QDIV;
                  end
               end
               R_ROOT34: begin
                  cmd.res_load  = 1'b1;
                  cmd.res_sel   = RES_PR;
                  cmd.res_found = 1'b1;
                  state_in      = S_FIN;
               end
               R_EUL_Z: begin
                  if (sts.pr_pm1) begin
                     cmd.pow_init = 1'b1;
                     cmd.pa_sel   = PA_Z;
                     cmd.pe_sel   = PE_Q;
                     ret_in       = R_C;
                     state_in     = S_POW;
                  end else begin
                     cmd.z_inc = 1'b1;
                     state_in  = S_ZCHK;
                  end
               end
               R_C: begin
                  cmd.c_from_pr = 1'b1;
                  cmd.pow_init  = 1'b1;
                  cmd.pa_sel    = PA_NR;
                  cmd.pe_sel    = PE_Q_HALF;
                  ret_in        = R_X;
                  state_in      = S_POW;
               end
               R_X: begin
                  cmd.x_from_pr = 1'b1;
                  cmd.pow_init  = 1'b1;
                  cmd.pa_sel    = PA_NR;
                  cmd.pe_sel    = PE_Q;
                  ret_in        = R_T;
                  state_in      = S_POW;
               end
               R_T: begin
                  cmd.t_from_pr = 1'b1;
                  cmd.m_from_s  = 1'b1;
                  state_in      = S_TS;
               end
               default: begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_ZERO;
                  state_in     = S_FIN;
               end
            endcase
         end
         S_QDIV: begin
            if (sts.q_lsb) begin
               cmd.z_init = 1'b1;
               state_in   = S_ZCHK;
            end else begin
               cmd.q_shift = 1'b1;
            end
         end
         S_ZCHK: begin
            if (sts.z_lim) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ZERO;
               state_in     = S_FIN;
            end else begin
               cmd.pow_init = 1'b1;
               cmd.pa_sel   = PA_Z;
               cmd.pe_sel   = PE_HALF_PM1;
               ret_in       = R_EUL_Z;
               state_in     = S_POW;
            end
         end
         S_TS: begin
            if (sts.t_one) begin
               cmd.res_load  = 1'b1;
               cmd.res_sel   = RES_X;
               cmd.res_found = 1'b1;
               state_in      = S_FIN;
            end else begin
               cmd.i_init    = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_a     = SEL_T;
               cmd.mul_b     = SEL_T;
               cmd.mul_dst   = SEL_TT;
               state_in      = S_SQ_W;
            end
         end
         S_SQ_W: begin
            if (sts.mul_done) state_in = S_ORD;
         end
         S_ORD: begin
            if (!sts.tt_one && sts.i_lt_m) begin
               cmd.i_inc     = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_a     = SEL_TT;
               cmd.mul_b     = SEL_TT;
               cmd.mul_dst   = SEL_TT;
               state_in      = S_SQ_W;
            end else if (!sts.i_lt_m) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ZERO;
               state_in     = S_FIN;
            end else begin
               cmd.b_from_c = 1'b1;
               cmd.j_init   = 1'b1;
               state_in     = S_BSQ;
            end
         end
         S_BSQ: begin
            cmd.mul_start = 1'b1;
            if (sts.j_lt) begin
               cmd.j_inc   = 1'b1;
               cmd.mul_a   = SEL_B;
               cmd.mul_b   = SEL_B;
               cmd.mul_dst = SEL_B;
               state_in    = S_BSQ_W;
            end else begin
               cmd.mul_a   = SEL_X;
               cmd.mul_b   = SEL_B;
               cmd.mul_dst = SEL_X;
               state_in    = S_XW;
            end
         end
         S_BSQ_W: begin
            if (sts.mul_done) state_in = S_BSQ;
         end
         S_XW: begin
            if (sts.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_a     = SEL_B;
               cmd.mul_b     = SEL_B;
               cmd.mul_dst   = SEL_C;
               state_in      = S_CW;
            end
         end
         S_CW: begin
            if (sts.mul_done) state_in = S_TM;
         end
         S_TM: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = SEL_T;
            cmd.mul_b     = SEL_C;
            cmd.mul_dst   = SEL_T;
            state_in      = S_TW;
         end
         S_TW: begin
            if (sts.mul_done) begin
               cmd.m_from_i = 1'b1;
               state_in     = S_TS;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= R_EUL_N;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- sv/modular_square_root_top.sv -----
// channel | dir | handshake     | payload
// req_ch  | in  | valid / ready | value (64b)
// rsp_ch  | out | valid / ready | root (64b), root_found (1b)
// csr     | in  | csr_wr_en     | csr_wr_data = modulus (64b), reset value 3
// One item at a time; a modular multiply runs bit by bit in the shared
// double-and-add unit, and each exponentiation takes up to 128 of them.
// Trivial cases are settled in S_CLASS without a multiply; Tonelli-Shanks
// items take far longer, more so on wide moduli or when the non-residue
// search or order loops run long.
// Reset is synchronous; a result waiting on rsp_ch does not block the next
// item, only the hand-off of the following result.
`include "assert_macros.svh"

module modular_square_root_top import msr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   msr_req_if.sink  req_ch,
   msr_rsp_if.source rsp_ch,
   input  logic     csr_wr_en,
   input  word_type csr_wr_data
);
   cmd_type cmd;
   sts_type sts;
   logic    req_ready, rsp_valid;

   msr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   msr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_value      (req_ch.value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_root       (rsp_ch.root),
      .rsp_root_found (rsp_ch.root_found)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   `MSR_ASSERT_NEXT(a_req_busy, req_ch.valid && req_ch.ready, !req_ch.ready)
   `MSR_ASSERT_IMPL(a_fail_zero, rsp_ch.valid && !rsp_ch.root_found, rsp_ch.root == '0)
   `MSR_ASSERT_IMPL(a_mul_idle, cmd.mul_start, !sts.mul_busy)
endmodule

// ----- dv/msr_checker.sv -----
`timescale 1ns / 100ps

module msr_checker import msr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   msr_req_if       req_ch,
   msr_rsp_if       rsp_ch,
   input  logic     csr_wr_en,
   input  word_type csr_wr_data,
   output int       pending,
   output int       errors
);

   typedef struct {
      word_type root;
      logic     found;
   } root_rec_type;

   word_type     field_modulus;
   root_rec_type root_q[$];

   function automatic word_type mulmod(word_type a, word_type b, word_type p);
      logic [127:0] prod;
      prod = {64'b0, a % p} * {64'b0, b % p};
      return word_type'(prod % {64'b0, p});
   endfunction

   function automatic word_type powmod(word_type a, word_type e, word_type p);
      word_type r;
      r = 1 % p;
      a = a % p;
      while (e != 0) begin
         if (e[0]) r = mulmod(r, a, p);
         a = mulmod(a, a, p);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic int legendre(word_type a, word_type p);
      word_type t;
      if (a % p == 0) return 0;
      t = powmod(a, (p - 1) >> 1, p);
      if (t == 1) return 1;
      return (t == p - 1) ? -1 : 0;
   endfunction

   function automatic root_rec_type predict_root(word_type n, word_type p);
      root_rec_type res;
      word_type     q, z, c, x, t, b, tt;
      int           s, m, i, j;
      res.root  = '0;
      res.found = 1'b0;
      if (n == 0) begin
         res.found = 1'b1;
         return res;
      end
      if (p == 2) begin
         res.root  = n & 1;
         res.found = 1'b1;
         return res;
      end
      if (p < 2) return res;
      if (legendre(n, p) != 1) return res;
      if (p[1:0] == 2'b11) begin
         res.root  = powmod(n, (p >> 2) + 1, p);
         res.found = 1'b1;
         return res;
      end
      q = p - 1;
      s = 0;
      while (!q[0]) begin
         q = q >> 1;
         s++;
      end
      for (z = 2; z < p && z < NR_LIMIT; z++)
         if (legendre(z, p) == -1) break;
      if (z >= p || z >= NR_LIMIT) return res;
      c = powmod(z, q, p);
      x = powmod(n, (q + 1) >> 1, p);
      t = powmod(n, q, p);
      m = s;
      while (t != 1) begin
         i  = 1;
         tt = mulmod(t, t, p);
         while (tt != 1 && i < m) begin
            tt = mulmod(tt, tt, p);
            i++;
         end
         if (i >= m) return res;
         b = c;
         for (j = 0; j < m - i - 1; j++) b = mulmod(b, b, p);
         x = mulmod(x, b, p);
         c = mulmod(b, b, p);
         t = mulmod(t, c, p);
         m = i;
      end
      res.root  = x;
      res.found = 1'b1;
      return res;
   endfunction

   initial begin
      errors  = 0;
      pending = 0;
      field_modulus = 3;
   end

   always @(posedge clock) begin
      root_rec_type exp_rec;
      if (reset) begin
         field_modulus = 3;
         root_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (root_q.size() == 0) begin
               $display("%0t: unexpected item root=%h found=%b", $time,
                        rsp_ch.root, rsp_ch.root_found);
               errors++;
            end else begin
               exp_rec = root_q.pop_front();
               if (rsp_ch.root !== exp_rec.root) begin
                  $display("%0t: root expected %h actual %h", $time,
                           exp_rec.root, rsp_ch.root);
                  errors++;
               end
               if (rsp_ch.root_found !== exp_rec.found) begin
                  $display("%0t: root_found expected %b actual %b", $time,
                           exp_rec.found, rsp_ch.root_found);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            root_q.push_back(predict_root(req_ch.value, field_modulus));
         if (csr_wr_en) field_modulus = csr_wr_data;
      end
      pending = root_q.size();
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench import msr_pkg::*;;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_wr_en = 1'b0;
   word_type csr_wr_data = '0;
   int       pending;
   int       errors;
   int       send_idle_pct = 0;
   int       rcv_stall_pct = 0;
   int       hold_cnt = 0;

   localparam word_type P_BIG_1MOD4 = 64'hFFFF_FFFF_FFFF_FFC5;
   localparam word_type P_MERSENNE  = 64'h1FFF_FFFF_FFFF_FFFF;
   localparam word_type W_MAX       = '1;

   msr_req_if req_if ();
   msr_rsp_if rsp_if ();

   modular_square_root_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if.sink),
      .rsp_ch      (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   msr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .errors      (errors)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
   end

   // hold off for a counted stretch, else stall at random
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_if.ready = 1'b0;
         hold_cnt--;
      end else begin
         rsp_if.ready = ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   initial begin
      #500_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_modulus(word_type p);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = p;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_item(word_type v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.value = v;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   function automatic word_type gen_value(word_type p);
      int           kind;
      word_type     r, sq;
      logic [127:0] big;
      kind = $urandom_range(0, 9);
      r    = rand_word() % p;
      sq   = word_type'(({64'b0, r} * {64'b0, r}) % {64'b0, p});
      if (kind < 5) begin
         big = {64'b0, sq} + {64'b0, p} * ($urandom_range(0, 3) ? 0 : $urandom);
         return (big[127:64] == 0) ? big[63:0] : sq;
      end
      if (kind < 8) return rand_word();
      if (kind == 8) begin
         big = {64'b0, p} * $urandom_range(1, 5);
         return (big[127:64] == 0) ? big[63:0] : p;
      end
      return $urandom_range(0, 1) ? W_MAX : '0;
   endfunction

   task automatic set_idle(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
         1: begin send_idle_pct = 88; rcv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rcv_stall_pct = 88; end
         default: begin send_idle_pct = 20; rcv_stall_pct = 20; end
      endcase
   endtask

   word_type moduli[10] = '{7, 11, 13, 17, 29, 41, 97, 257, 1009, 12289};

   initial begin
      word_type p;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_item(0);
      send_item(1);
      send_item(2);
      send_item(3);
      send_item(W_MAX);
      send_item(64'h8000_0000_0000_0000);

      set_modulus(2);
      send_item(0);
      send_item(1);
      send_item(W_MAX - 1);
      send_item(W_MAX);

      set_modulus(13);
      send_item(1);
      send_item(2);
      send_item(3);
      send_item(26);
      send_item(W_MAX);

      set_modulus(65537);
      send_item(9);
      send_item(3);

      set_modulus(21);
      send_item(4);

      set_modulus(P_BIG_1MOD4);
      send_item(4);
      send_item(P_BIG_1MOD4 - 1);

      set_modulus(P_MERSENNE);
      send_item(9);
      send_item(W_MAX);

      set_modulus(W_MAX);
      send_item(4);
      send_item(5);

      for (int ph = 0; ph < 9; ph++) begin
         p = moduli[$urandom_range(0, 9)];
         if (ph == 8) p = P_MERSENNE;
         set_modulus(p);
         set_idle(ph % 4);
         if (ph == 2) hold_cnt = 200000;
         for (int n = 0; n < ((ph == 8) ? 4 : 12); n++) begin
            if (ph == 5 && n == 6) drain();
            send_item(gen_value(p));
         end
      end

      set_idle(0);
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
